[sv/vdib_pkg.sv]
// ----------------------------------------------------------------------------
// Vertex dedup package
// Shared types and codes for the vertex deduplication index builder.
// ----------------------------------------------------------------------------
package vdib_pkg;

  typedef enum logic [2:0] {
    CMD_LOAD_POS  = 3'd0,
    CMD_LOAD_NORM = 3'd1,
    CMD_LOAD_TEX  = 3'd2,
    CMD_CORNER    = 3'd3,
    CMD_CLEAR     = 3'd4
  } cmd_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam int VERT_WORDS = 3 + 3 + 2;
  localparam int VERT_BITS  = 32 * VERT_WORDS;
  localparam int IDX_W      = 11;
  localparam int EIDX_W     = 10;

  // One input transaction.
  typedef struct packed {
    logic [2:0]       command;
    logic [31:0]      value_x;
    logic [31:0]      value_y;
    logic [31:0]      value_z;
    logic [IDX_W-1:0] position_index;
    logic [IDX_W-1:0] texture_index;
    logic [IDX_W-1:0] normal_index;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]        status;
    logic [EIDX_W-1:0] element_index;
    logic              new_vertex;
    logic [31:0]       pos_x;
    logic [31:0]       pos_y;
    logic [31:0]       pos_z;
    logic [31:0]       norm_x;
    logic [31:0]       norm_y;
    logic [31:0]       norm_z;
    logic [31:0]       tex_u;
    logic [31:0]       tex_v;
  } out_item_t;

  // Float equality of one word: signed zeros match, NaN never matches.
  function automatic logic word_eq(input logic [31:0] a, input logic [31:0] b);
    logic nan_a;
    logic nan_b;
    nan_a = a[30:0] > 31'h7F800000;
    nan_b = b[30:0] > 31'h7F800000;
    if (nan_a || nan_b) return 1'b0;
    if ((a[30:0] | b[30:0]) == 31'd0) return 1'b1;
    return a == b;
  endfunction

  function automatic logic vert_eq(input logic [VERT_BITS-1:0] a,
                                   input logic [VERT_BITS-1:0] b);
    logic r;
    r = 1'b1;
    for (int k = 0; k < VERT_WORDS; k++) begin
      r = r & word_eq(a[32*k +: 32], b[32*k +: 32]);
    end
    return r;
  endfunction

endpackage

[sv/vdib_if.sv]
// ----------------------------------------------------------------------------
// Vertex dedup channel interfaces
// Valid/ready channels for input and result transactions.
// ----------------------------------------------------------------------------
interface vdib_in_if import vdib_pkg::*; (input logic clk);
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vdib_out_if import vdib_pkg::*; (input logic clk);
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/vdib_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module vdib_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[sv/vdib_fifo.sv]
// ----------------------------------------------------------------------------
// Vertex dedup command queue
// Two-entry queue between the front and the back part.
// ----------------------------------------------------------------------------
module vdib_fifo import vdib_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output in_item_t pop_data
);
  in_item_t   slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;

  assign full     = fill == 2'd2;
  assign empty    = fill == 2'd0;
  assign pop_data = slots[rptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr <= ~wptr;
      end
      if (pop && !empty) begin
        rptr <= ~rptr;
      end
      fill <= fill + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end

  // Payload storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= push_data;
    end
  end
endmodule

[sv/vdib_back.sv]
// ----------------------------------------------------------------------------
// Vertex dedup back end
// Executes queued commands: stores, gathers and searches the vertex table.
// ----------------------------------------------------------------------------
module vdib_back import vdib_pkg::*; #(
  parameter int MAX_POSITIONS = 1024,
  parameter int MAX_NORMALS   = 1024,
  parameter int MAX_TEXCOORDS = 1024,
  parameter int MAX_UNIQUE    = 1024
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  in_item_t  q_data,
  output logic      q_pop,
  output logic      res_valid,
  input  logic      res_ready,
  output out_item_t res_data
);
  localparam int PA = $clog2(MAX_POSITIONS);
  localparam int NA = $clog2(MAX_NORMALS);
  localparam int TA = $clog2(MAX_TEXCOORDS);
  localparam int UA = $clog2(MAX_UNIQUE);
  localparam int PC = $clog2(MAX_POSITIONS + 1);
  localparam int NC = $clog2(MAX_NORMALS + 1);
  localparam int TC = $clog2(MAX_TEXCOORDS + 1);
  localparam int UC = $clog2(MAX_UNIQUE + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_GATHER, S_LATCH, S_SEARCH, S_CHECK, S_OUT
  } state_t;

  state_t          state;
  logic [PC-1:0]   position_count;
  logic [NC-1:0]   normal_count;
  logic [TC-1:0]   texcoord_count;
  logic [UC-1:0]   unique_count;
  logic [UC-1:0]   scan;
  logic [VERT_BITS-1:0] vert;
  out_item_t       res;

  logic            do_pos;
  logic            do_norm;
  logic            do_tex;
  logic            do_uniq;
  logic [95:0]     pos_rd;
  logic [95:0]     norm_rd;
  logic [63:0]     tex_rd;
  logic [VERT_BITS-1:0] uniq_rd;
  logic [PA-1:0]   pos_ra;
  logic [NA-1:0]   norm_ra;
  logic [TA-1:0]   tex_ra;
  logic            bad_corner;
  logic            idle_take;

  assign idle_take = state == S_IDLE && !q_empty;
  assign q_pop     = idle_take;
  assign res_valid = state == S_OUT;
  assign res_data  = res;

  // Write enables for the attribute stores.
  assign do_pos  = idle_take && q_data.command == CMD_LOAD_POS
                   && position_count < PC'(MAX_POSITIONS);
  assign do_norm = idle_take && q_data.command == CMD_LOAD_NORM
                   && normal_count < NC'(MAX_NORMALS);
  assign do_tex  = idle_take && q_data.command == CMD_LOAD_TEX
                   && texcoord_count < TC'(MAX_TEXCOORDS);
  assign do_uniq = state == S_CHECK && unique_count < UC'(MAX_UNIQUE);

  // Face corner validity check against the fill counts.
  assign bad_corner = position_count == '0 || normal_count == '0
    || texcoord_count == '0
    || q_data.position_index == '0 || 32'(q_data.position_index) > 32'(position_count)
    || q_data.normal_index == '0 || 32'(q_data.normal_index) > 32'(normal_count)
    || q_data.texture_index == '0 || 32'(q_data.texture_index) > 32'(texcoord_count);

  assign pos_ra  = PA'(q_data.position_index - 11'd1);
  assign norm_ra = NA'(q_data.normal_index - 11'd1);
  assign tex_ra  = TA'(q_data.texture_index - 11'd1);

  vdib_ram #(.WIDTH(96), .DEPTH(MAX_POSITIONS)) u_pos (
    .clk, .we(do_pos), .waddr(PA'(position_count)),
    .wdata({q_data.value_z, q_data.value_y, q_data.value_x}),
    .raddr(pos_ra), .rdata(pos_rd));
  vdib_ram #(.WIDTH(96), .DEPTH(MAX_NORMALS)) u_norm (
    .clk, .we(do_norm), .waddr(NA'(normal_count)),
    .wdata({q_data.value_z, q_data.value_y, q_data.value_x}),
    .raddr(norm_ra), .rdata(norm_rd));
  vdib_ram #(.WIDTH(64), .DEPTH(MAX_TEXCOORDS)) u_tex (
    .clk, .we(do_tex), .waddr(TA'(texcoord_count)),
    .wdata({q_data.value_y, q_data.value_x}),
    .raddr(tex_ra), .rdata(tex_rd));
  vdib_ram #(.WIDTH(VERT_BITS), .DEPTH(MAX_UNIQUE)) u_uniq (
    .clk, .we(do_uniq), .waddr(UA'(unique_count)), .wdata(vert),
    .raddr(UA'(scan)), .rdata(uniq_rd));

  // Sequencer: compares one table entry per pass through the search and check states.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      position_count <= '0;
      normal_count   <= '0;
      texcoord_count <= '0;
      unique_count   <= '0;
      scan           <= '0;
      res            <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            state <= S_OUT;
            case (q_data.command)
              CMD_LOAD_POS: begin
                if (do_pos) position_count <= position_count + PC'(1);
                else res.status <= ST_FULL;
              end
              CMD_LOAD_NORM: begin
                if (do_norm) normal_count <= normal_count + NC'(1);
                else res.status <= ST_FULL;
              end
              CMD_LOAD_TEX: begin
                if (do_tex) texcoord_count <= texcoord_count + TC'(1);
                else res.status <= ST_FULL;
              end
              CMD_CORNER: begin
                if (bad_corner) begin
                  res.status <= ST_MISS;
                end else begin
                  state <= S_GATHER;
                end
              end
              CMD_CLEAR: begin
                position_count <= '0;
                normal_count   <= '0;
                texcoord_count <= '0;
                unique_count   <= '0;
                scan           <= '0;
              end
              default: ;
            endcase
          end
        end
        S_GATHER: begin
          // Store data read for the popped corner is valid only in this cycle.
          vert  <= {tex_rd, norm_rd, pos_rd};
          state <= S_LATCH;
        end
        S_LATCH: begin
          scan  <= '0;
          state <= S_SEARCH;
        end
        S_SEARCH: begin
          // Address for entry scan is presented; data arrives next cycle.
          if (scan == unique_count) begin
            state <= S_CHECK;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (scan != unique_count && vert_eq(uniq_rd, vert)) begin
            res.element_index <= EIDX_W'(scan);
            state <= S_OUT;
          end else if (scan != unique_count) begin
            scan  <= scan + UC'(1);
            state <= S_SEARCH;
          end else if (unique_count >= UC'(MAX_UNIQUE)) begin
            res.status <= ST_FULL;
            state <= S_OUT;
          end else begin
            res.element_index <= EIDX_W'(unique_count);
            res.new_vertex    <= 1'b1;
            res.pos_x  <= vert[31:0];
            res.pos_y  <= vert[63:32];
            res.pos_z  <= vert[95:64];
            res.norm_x <= vert[127:96];
            res.norm_y <= vert[159:128];
            res.norm_z <= vert[191:160];
            res.tex_u  <= vert[223:192];
            res.tex_v  <= vert[255:224];
            unique_count <= unique_count + UC'(1);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready) begin
            state <= S_IDLE;
            res   <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks on the sequencer.
  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    unique_count <= UC'(MAX_UNIQUE)) else $error("unique count overflow");
  a_scan_max: assert property (@(posedge clk) disable iff (rst)
    scan <= unique_count) else $error("scan beyond table");
  a_new_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.new_vertex |-> res.status == ST_OK)
    else $error("new vertex with error status");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state != S_IDLE) else $error("pop without work");
endmodule

[sv/vertex_dedup_index_builder.sv]
// Loads, clears, unknown commands and rejected corners go from the idle state straight
// to the result state; a face corner passes through gather and latch, then one search
// and check step per table entry compared, until a match or the end of the table.
// One item is in the back part at a time; the next is popped once the result is taken.
// Reset (synchronous, rst high) empties the queue and zeroes every fill count;
// store contents are undefined until written.
module vertex_dedup_index_builder import vdib_pkg::*; #(
  parameter int MAX_POSITIONS = 1024,
  parameter int MAX_NORMALS   = 1024,
  parameter int MAX_TEXCOORDS = 1024,
  parameter int MAX_UNIQUE    = 1024
) (
  input logic       clk,
  input logic       rst,
  vdib_in_if.sink   in_ch,
  vdib_out_if.source out_ch
);
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  in_item_t q_data;

  // Front part: accept into the queue whenever there is room.
  assign in_ch.ready = !q_full;

  vdib_fifo u_fifo (
    .clk, .rst, .push(in_ch.valid), .push_data(in_ch.data), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_data(q_data));

  vdib_back #(
    .MAX_POSITIONS(MAX_POSITIONS), .MAX_NORMALS(MAX_NORMALS),
    .MAX_TEXCOORDS(MAX_TEXCOORDS), .MAX_UNIQUE(MAX_UNIQUE)
  ) u_back (
    .clk, .rst, .q_empty, .q_data, .q_pop,
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res_data(out_ch.data));
endmodule
